[sv/bba_pkg.sv]
// Shared types, constants and helpers of the bitmap block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned DEF_BITMAP_BITS = 32768;
  localparam int unsigned MAX_IDX_W       = 20;   // bitmap of up to 2^20 blocks
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLOCK  = CFG_IDX_W'(1);

  typedef struct packed {
    logic        action;        // 0 allocate, 1 free
    logic [31:0] block_number;
  } bba_in_t;

  typedef struct packed {
    logic [31:0] allocated_block;
    logic        ok;
  } bba_out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                 is_free;
    logic                 in_range;
    logic [MAX_IDX_W-1:0] idx;
  } bba_cmd_t;

  // Effective limit: the smaller of block_count and the bitmap size.
  function automatic logic [MAX_IDX_W:0] eff_limit(input logic [15:0] cnt,
                                                   input logic [31:0] bits);
    logic [31:0] c;
    c = 32'(cnt);
    if (c > bits) begin
      return bits[MAX_IDX_W:0];
    end
    return c[MAX_IDX_W:0];
  endfunction

endpackage

[sv/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter  int unsigned WIDTH  = 32,
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bba_front.sv]
// Request front end: accept, turn a free into a bitmap index, range check.
`timescale 1ns / 1ps
module bba_front
  import bba_pkg::*;
#(
  parameter int unsigned BITMAP_BITS = DEF_BITMAP_BITS
) (
  input  logic        start_i,
  input  logic        busy_i,
  input  bba_in_t     in_i,
  input  logic [15:0] block_count_i,
  input  logic [31:0] base_block_i,
  output logic        push_o,
  output bba_cmd_t    cmd_o
);

  localparam int unsigned IDX_W = $clog2(BITMAP_BITS);

  logic [MAX_IDX_W:0] lim;
  logic [31:0]        diff;

  always_comb begin
    lim  = eff_limit(block_count_i, 32'(BITMAP_BITS));
    diff = in_i.block_number - base_block_i;
    push_o         = start_i & ~busy_i;
    cmd_o.is_free  = in_i.action;
    cmd_o.in_range = diff < 32'(lim);
    cmd_o.idx      = MAX_IDX_W'(diff[IDX_W-1:0]);
  end

endmodule

[sv/bba_queue.sv]
// Short FIFO of classified requests between front and back.
`timescale 1ns / 1ps
module bba_queue
  import bba_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bba_cmd_t cmd_i,
  input  logic     pop_i,
  output bba_cmd_t cmd_o,
  output logic     valid_o,
  output logic     full_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bba_cmd_t         buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign cmd_o   = buf_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/bba_back.sv]
// Back end: bitmap RAM, clearing pass, first-fit scan and free update.
`timescale 1ns / 1ps
module bba_back
  import bba_pkg::*;
#(
  parameter int unsigned BITMAP_BITS = DEF_BITMAP_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] block_count_i,
  input  logic [31:0] base_block_i,
  input  bba_cmd_t    cmd_i,
  input  logic        cmd_valid_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        done_o,
  output bba_out_t    res_o
);

  localparam int unsigned MAP_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SW        = $clog2(MAP_WORDS + 1);
  localparam int unsigned IDX_W     = $clog2(BITMAP_BITS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE,
    S_FREE
  } state_e;

  state_e           state_q, state_d;
  logic [SW-1:0]    scan_w_q, scan_w_d;
  logic [AW-1:0]    chk_w_q, chk_w_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             done_q, done_d;
  bba_out_t         res_q, res_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [31:0] lim32;
  logic        issue_ok;
  logic        any_free;
  logic [4:0]  bit_sel;
  logic [31:0] cand;

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Lowest clear bit of the word just read.
  always_comb begin
    any_free = ~&ram_rdata;
    bit_sel  = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        bit_sel = 5'(b);
      end
    end
    cand = (32'(chk_w_q) << 5) | 32'(bit_sel);
  end

  always_comb begin
    lim32    = 32'(eff_limit(block_count_i, 32'(BITMAP_BITS)));
    issue_ok = (32'(scan_w_q) < 32'(MAP_WORDS)) && ((32'(scan_w_q) << 5) < lim32);

    state_d  = state_q;
    scan_w_d = scan_w_q;
    chk_w_d  = chk_w_q;
    pend_d   = pend_q;
    clr_d    = clr_q;
    found_d  = found_q;
    idx_d    = idx_q;
    done_d   = 1'b0;
    res_d    = res_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = AW'(scan_w_q);
    pop_o     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          if (cmd_i.is_free) begin
            if (cmd_i.in_range) begin
              idx_d     = cmd_i.idx[IDX_W-1:0];
              ram_raddr = AW'(cmd_i.idx[IDX_W-1:0] >> 5);
              state_d   = S_FREE;
            end else begin
              done_d = 1'b1;
              res_d  = '0;
            end
          end else begin
            scan_w_d = '0;
            pend_d   = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && any_free) begin
          if (cand < lim32) begin
            ram_we    = 1'b1;
            ram_waddr = chk_w_q;
            ram_wdata = ram_rdata | (32'(1) << bit_sel);
            found_d   = 1'b1;
            idx_d     = IDX_W'(cand);
          end else begin
            found_d = 1'b0;
          end
          state_d = S_DONE;
        end else if (!pend_q && !issue_ok) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          pend_d  = issue_ok;
          chk_w_d = AW'(scan_w_q);
          if (issue_ok) begin
            scan_w_d = scan_w_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        done_d                = 1'b1;
        res_d.ok              = found_q;
        res_d.allocated_block = found_q ? base_block_i + 32'(idx_q) : '0;
        state_d               = S_IDLE;
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_q >> 5);
        ram_wdata = ram_rdata & ~(32'(1) << idx_q[4:0]);
        done_d    = 1'b1;
        res_d     = '{allocated_block: '0, ok: 1'b1};
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      scan_w_q <= '0;
      chk_w_q  <= '0;
      pend_q   <= 1'b0;
      clr_q    <= '0;
      found_q  <= 1'b0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      scan_w_q <= scan_w_d;
      chk_w_q  <= chk_w_d;
      pend_q   <= pend_d;
      clr_q    <= clr_d;
      found_q  <= found_d;
      idx_q    <= idx_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  assign clearing_o = state_q == S_CLEAR;
  assign done_o     = done_q;
  assign res_o      = res_q;

endmodule

[sv/bitmap_block_allocator_unit.sv]
// Top level of the first-fit bitmap block allocator.
`timescale 1ns / 1ps
// First-fit block allocator over a bitmap of used blocks, one bit per block,
// held in a RAM of 32-bit words (BITMAP_BITS/32 words). A request is taken
// when start is high and busy is low; action 0 allocates the lowest free
// block below min(block_count, BITMAP_BITS) and returns base_block plus its
// index, action 1 frees block_number (ok low and nothing changed when the
// block lies outside the partition). Each request gives exactly one result,
// shown for a single cycle with done_o high; the receiver cannot stall it,
// so sample res_o whenever done_o is set. Requests go into a two-entry queue,
// so up to two can be sent while an earlier one is still being worked on;
// busy rises when the queue is full. A free reads its bitmap word and clears
// the bit in the S_FREE state; one rejected as out of range is answered from
// the idle state. An allocate scans one bitmap word per cycle through the RAM
// read port and stops at the first word with a clear bit, or at the limit on
// a full map. After reset busy stays high while a clearing pass zeroes all
// BITMAP_BITS/32 words (1024 at the default size) of the RAM; configuration
// writes are taken at any time but must only be made while no request is in
// flight.
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned BITMAP_BITS = DEF_BITMAP_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bba_in_t               in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output bba_out_t              res_o
);

  logic [15:0] block_count_q;
  logic [31:0] base_block_q;

  logic     push;
  bba_cmd_t front_cmd;
  bba_cmd_t queue_cmd;
  logic     queue_valid;
  logic     queue_full;
  logic     pop;
  logic     clearing;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      base_block_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_COUNT: block_count_q <= cfg_data_i[15:0];
        REG_BASE_BLOCK:  base_block_q  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new requests during the clearing pass or with the queue full.
  assign busy = clearing | queue_full;

  bba_front #(
    .BITMAP_BITS(BITMAP_BITS)
  ) u_front (
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_i),
    .block_count_i(block_count_q),
    .base_block_i (base_block_q),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  bba_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .valid_o(queue_valid),
    .full_o (queue_full)
  );

  bba_back #(
    .BITMAP_BITS(BITMAP_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .block_count_i(block_count_q),
    .base_block_i (base_block_q),
    .cmd_i        (queue_cmd),
    .cmd_valid_i  (queue_valid),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .res_o        (res_o)
  );

endmodule

[verif/tb_bitmap_block_allocator_unit.sv]
// Self-checking testbench of the bitmap block allocator: directed table, then random phases.
`timescale 1ns / 1ps
module tb_bitmap_block_allocator_unit;
  import bba_pkg::*;

  // Bitmap size of the instance and of the local copy of the map.
  localparam int unsigned MAP_BITS  = DEF_BITMAP_BITS;
  localparam int unsigned MAP_WORDS = MAP_BITS / WORD_BITS;

  // Request codes carried in the action field.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Register indexes with no register behind them; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  // Every request gives a result, so the block is idle once no result is owed.
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam int RAND_PHASES     = 15;
  localparam int ITEMS_PER_PHASE = 60;

  typedef enum logic [1:0] {
    ROW_WRITE,    // register write, taken once the block is idle
    ROW_PREDICT,  // request checked against the predictor
    ROW_FIXED     // request with its result typed in
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          wdata;
    bba_in_t              req;
    bba_out_t             want;
  } dir_row_t;

  localparam int DIR_LEN = 35;

  // Directed table: reset state, zero count, wrap of base plus index, full
  // map, out-of-range and double frees, ignored register indexes, a count
  // beyond the bitmap, and the top of the bitmap.
  localparam dir_row_t DIR_ROWS [0:DIR_LEN-1] = '{
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0000_0000, '{ACT_ALLOC, 32'hFFFF_FFFF}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0000_0000, '{ACT_FREE,  32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BLOCK_COUNT, 32'hFFFF_0004, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BASE_BLOCK,  32'hFFFF_FFFE, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'hFFFF_FFFE, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h5555_5555}, '{32'hFFFF_FFFF, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'hAAAA_AAAA}, '{32'h0000_0000, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0000_0001, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'hFFFF_FFFF}, '{32'h0, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'hFFFF_FFFF}, '{32'h0, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h0000_0002}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'hFFFF_FFFD}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'hFFFF_FFFF, 1'b1}},
    '{ROW_WRITE,   REG_SPARE_2,     32'hFFFF_FFFF, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_SPARE_3,     32'h0000_0000, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BLOCK_COUNT, 32'h0000_FFFF, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BASE_BLOCK,  32'h0000_0000, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h0000_7FFF}, '{32'h0, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h0000_8000}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'hFFFF_FFFF}, '{32'h0, 1'b0}},
    '{ROW_PREDICT, REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'hFFFF_FFFF}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BLOCK_COUNT, 32'h0000_8000, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BASE_BLOCK,  32'h8000_0000, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_PREDICT, REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h8000_7FFF}, '{32'h0, 1'b1}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h7FFF_FFFF}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BLOCK_COUNT, 32'h0000_0000, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_FIXED,   REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h8000_0000}, '{32'h0, 1'b0}},
    '{ROW_WRITE,   REG_BLOCK_COUNT, 32'h0000_0001, '{ACT_ALLOC, 32'h0}, '{32'h0, 1'b0}},
    '{ROW_PREDICT, REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}},
    '{ROW_PREDICT, REG_BLOCK_COUNT, 32'h0, '{ACT_FREE,  32'h8000_0000}, '{32'h0, 1'b0}},
    '{ROW_PREDICT, REG_BLOCK_COUNT, 32'h0, '{ACT_ALLOC, 32'h0000_0000}, '{32'h0, 1'b0}}
  };

  // Clock and stimulus signals; every input holds a known value from time 0.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  bba_in_t               in_i        = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy;
  logic                  done_o;
  bba_out_t              res_o;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bitmap_block_allocator_unit #(
    .BITMAP_BITS(MAP_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  // Local copy of the used-block map and of the partition registers.
  logic [31:0] used_words [MAP_WORDS];
  logic [15:0] part_count;
  logic [31:0] part_base;

  // Results owed by the block, oldest first.
  bba_out_t pending_results [$];
  bba_out_t got_want;

  int err_cnt     = 0;
  int n_granted   = 0;
  int n_refused   = 0;
  int n_freed     = 0;
  int n_rejected  = 0;
  int n_writes    = 0;

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Allocation limit: block count clamped to the bitmap size.
  function automatic int unsigned part_limit();
    return (part_count > MAP_BITS) ? MAP_BITS : int'(part_count);
  endfunction

  // Work out the result of one request and update the local map.
  function automatic bba_out_t predict_allocation(input bba_in_t req);
    bba_out_t    res;
    int unsigned lim;
    int unsigned w;
    int unsigned b;
    int unsigned idx;
    logic [31:0] offs;
    bit          found;
    bit          stop;
    res   = '0;
    lim   = part_limit();
    found = 1'b0;
    stop  = 1'b0;
    idx   = 0;
    if (req.action == ACT_ALLOC) begin
      // First fit: walk words from the bottom, stop at the first clear bit.
      w = 0;
      while (!found && !stop && w < MAP_WORDS && w * 32 < lim) begin
        if (used_words[w] != '1) begin
          b = 0;
          while (used_words[w][b]) b++;
          idx = w * 32 + b;
          if (idx < lim) found = 1'b1;
          else stop = 1'b1;
        end
        w++;
      end
      if (found) begin
        used_words[idx / 32][idx % 32] = 1'b1;
        res.allocated_block = part_base + 32'(idx);
        res.ok              = 1'b1;
      end
    end else begin
      // Index wraps modulo 2^32, so blocks below the base land far out of range.
      offs = req.block_number - part_base;
      if (offs < lim) begin
        used_words[offs[14:5]][offs[4:0]] = 1'b0;
        res.ok = 1'b1;
      end
    end
    return res;
  endfunction

  // Hold start low until every owed result has come back, then let the
  // block settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BLOCK_COUNT) begin
      part_count = val[15:0];
    end else if (idx == REG_BASE_BLOCK) begin
      part_base = val;
    end
    n_writes++;
  endtask

  // Drive one request, wait out busy, then record what the block owes.
  // With use_fixed set the typed-in result is owed; the map is updated anyway.
  task automatic send_request(input bba_in_t req, input bit no_gap, input bit use_fixed,
                              input bba_out_t fixed_res);
    int unsigned gap;
    bba_out_t    res;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= req;
    do @(posedge clk_i); while (busy);
    // Transfer happened at this edge.
    res = predict_allocation(req);
    if (use_fixed) res = fixed_res;
    if (req.action == ACT_ALLOC) begin
      if (res.ok) n_granted++;
      else n_refused++;
    end else begin
      if (res.ok) n_freed++;
      else n_rejected++;
    end
    pending_results.push_back(res);
  endtask

  // Every result is checked at the edge that ends its one-cycle window.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result block %h ok %b with nothing outstanding",
                                res_o.allocated_block, res_o.ok));
      end else begin
        got_want = pending_results.pop_front();
        if (res_o.allocated_block !== got_want.allocated_block) begin
          flag_mismatch($sformatf("allocated_block %h, wanted %h",
                                  res_o.allocated_block, got_want.allocated_block));
        end
        if (res_o.ok !== got_want.ok) begin
          flag_mismatch($sformatf("ok %b, wanted %b", res_o.ok, got_want.ok));
        end
      end
    end
  end

  initial begin
    int unsigned cnt;
    int unsigned lim;
    int unsigned r;
    int unsigned alloc_pct;
    logic [31:0] base;
    bit          no_gap;
    bba_in_t     req;

    foreach (used_words[i]) used_words[i] = '0;
    part_count = '0;
    part_base  = '0;

    // Hold reset low from time 0, then release it for good.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table; requests simply stall through the clearing pass.
    for (int r_i = 0; r_i < DIR_LEN; r_i++) begin
      if (DIR_ROWS[r_i].kind == ROW_WRITE) begin
        write_reg(DIR_ROWS[r_i].reg_idx, DIR_ROWS[r_i].wdata);
      end else begin
        send_request(DIR_ROWS[r_i].req, 1'b0, DIR_ROWS[r_i].kind == ROW_FIXED,
                     DIR_ROWS[r_i].want);
      end
    end

    // Random phases: new partition settings, then a burst of requests.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // Mostly small partitions so the map fills and drains; a few at the extremes.
      case ($urandom_range(0, 9)) inside
        [0:5]: cnt = $urandom_range(1, 64);
        [6:7]: cnt = $urandom_range(65, 1024);
        8: begin
          case ($urandom_range(0, 2))
            0:       cnt = MAP_BITS;
            1:       cnt = 65535;
            default: cnt = $urandom_range(MAP_BITS + 1, 65535);
          endcase
        end
        default: cnt = $urandom_range(0, 1);
      endcase
      case ($urandom_range(0, 7))
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF - $urandom_range(0, 40);
        2:       base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      // Junk in the upper half of the count word must be dropped.
      if ($urandom_range(0, 1)) begin
        write_reg(REG_BLOCK_COUNT, {16'($urandom), 16'(cnt)});
        write_reg(REG_BASE_BLOCK, base);
      end else begin
        write_reg(REG_BASE_BLOCK, base);
        write_reg(REG_BLOCK_COUNT, {16'($urandom), 16'(cnt)});
      end
      lim    = part_limit();
      no_gap = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 25;
        1:       alloc_pct = 55;
        default: alloc_pct = 85;
      endcase

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          req.action       = ACT_ALLOC;
          req.block_number = $urandom;
        end else begin
          req.action = ACT_FREE;
          r = $urandom_range(0, 99);
          if (r < 50) begin
            // Low region, where most used blocks sit.
            req.block_number = part_base + $urandom_range(0, ((lim < 64) ? lim : 64) + 2);
          end else if (r < 70) begin
            req.block_number = part_base + $urandom_range(0, lim + 4);
          end else if (r < 85) begin
            req.block_number = part_base - $urandom_range(1, 4);
          end else begin
            req.block_number = $urandom;
          end
        end
        send_request(req, no_gap, 1'b0, '0);
      end
    end

    // Drop start, drain, and watch a while longer for stray results.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d allocates (%0d granted, %0d refused) and %0d frees %s",
             n_granted + n_refused, n_granted, n_refused, n_freed + n_rejected,
             $sformatf("(%0d applied, %0d rejected)", n_freed, n_rejected));
    $display("across %0d register writes, %0d random partition settings, %0d mismatches.",
             n_writes, RAND_PHASES, err_cnt);
    if (err_cnt == 0) begin
      $display("** bitmap_block_allocator_unit: PASSED **");
    end else begin
      $display("** bitmap_block_allocator_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included.
  initial begin
    #200_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("** bitmap_block_allocator_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_front.sv
sv/bba_queue.sv
sv/bba_back.sv
sv/bitmap_block_allocator_unit.sv
verif/tb_bitmap_block_allocator_unit.sv
